@@ sv/fxalu_pkg.sv @@
`timescale 1ns / 1ps
// fxalu_pkg: opcode and status codes for the q24.8 fixed point alu
// no dependencies; imported by fixed_point_q24_8_alu_unit

package fxalu_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_INC      = 4'd10,
      OP_DEC      = 4'd11,
      OP_MIN      = 4'd12,
      OP_MAX      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

endpackage

@@ sv/fixed_point_q24_8_alu_unit.sv @@
`timescale 1ns / 1ps
// fixed_point_q24_8_alu_unit: signed fixed point alu, pipelined shift-add
// multiplier and restoring divider; depends on fxalu_pkg
// pipeline: input register, divider iteration stages with one quotient bit per
// divider stage, then a rounding stage and a saturation and output stage
// throughput: one item per cycle; a stalled rsp holds the whole pipeline
// reset: synchronous, active high, clears the valid bits of every stage

module fixed_point_q24_8_alu_unit
   import fxalu_pkg::*;
#(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode[3:0], operand_a, operand_b, zero fill
   input  logic [((4 + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_value, compare_true, status[1:0], zero fill
   output logic [((DATA_WIDTH + 3 + 7) / 8) * 8 - 1:0]     rsp_tdata
);

   localparam int W         = DATA_WIDTH;
   localparam int F         = FRAC_BITS;
   localparam int D         = W + F;
   localparam int PW        = 2 * W + 1;
   localparam int MAGW      = (PW > D + 1) ? PW : D + 1;
   localparam int REQ_BITS  = 4 + 2 * W;
   localparam int REQ_TDATA = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = W + 3;
   localparam int RSP_TDATA = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [W-1:0]    POSMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]    SIGNBIT   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]    HI_LIM    = POSMAX >> F;
   localparam logic [W-1:0]    LO_LIM    = ~HI_LIM;
   localparam logic [PW-1:0]   ROUND_ADD = PW'(1) << (F - 1);
   localparam logic [MAGW-1:0] LIM_POS   = MAGW'(POSMAX);
   localparam logic [MAGW-1:0] LIM_NEG   = MAGW'(SIGNBIT);

   logic adv;

   // ---------------- input decode ----------------
   opcode_type   in_op;
   logic [W-1:0] in_a, in_b, sum, dif, s_res, ma, mb;
   logic         s_cmp, na, nb;
   status_type   s_stat;

   assign in_op = opcode_type'(req_tdata[3:0]);
   assign in_a  = req_tdata[4 +: W];
   assign in_b  = req_tdata[4 + W +: W];
   assign na    = in_a[W-1];
   assign nb    = in_b[W-1];
   assign ma    = na ? W'(-in_a) : in_a;
   assign mb    = nb ? W'(-in_b) : in_b;
   assign sum   = in_a + in_b;
   assign dif   = in_a - in_b;

   always_comb begin
      s_res  = '0;
      s_cmp  = 1'b0;
      s_stat = ST_OK;
      case (in_op)
         OP_ADD: begin
            s_res = sum;
            if (na == nb && sum[W-1] != na) begin
               s_stat = ST_OVERFLOW;
               s_res  = na ? SIGNBIT : POSMAX;
            end
         end
         OP_SUB: begin
            s_res = dif;
            if (na != nb && dif[W-1] != na) begin
               s_stat = ST_OVERFLOW;
               s_res  = na ? SIGNBIT : POSMAX;
            end
         end
         OP_DIV: begin
            if (in_b == '0) s_stat = ST_DIV_ZERO;
         end
         OP_GT: s_cmp = $signed(in_a) > $signed(in_b);
         OP_LT: s_cmp = $signed(in_a) < $signed(in_b);
         OP_GE: s_cmp = $signed(in_a) >= $signed(in_b);
         OP_LE: s_cmp = $signed(in_a) <= $signed(in_b);
         OP_EQ: s_cmp = in_a == in_b;
         OP_NE: s_cmp = in_a != in_b;
         OP_INC: begin
            if (in_a == POSMAX) begin
               s_stat = ST_OVERFLOW;
               s_res  = POSMAX;
            end else begin
               s_res = in_a + W'(1);
            end
         end
         OP_DEC: begin
            if (in_a == SIGNBIT) begin
               s_stat = ST_OVERFLOW;
               s_res  = SIGNBIT;
            end else begin
               s_res = in_a - W'(1);
            end
         end
         OP_MIN: s_res = ($signed(in_b) > $signed(in_a)) ? in_a : in_b;
         OP_MAX: s_res = ($signed(in_a) > $signed(in_b)) ? in_a : in_b;
         OP_FROM_INT: begin
            if ($signed(in_a) > $signed(HI_LIM)) begin
               s_stat = ST_OVERFLOW;
               s_res  = POSMAX;
            end else if ($signed(in_a) < $signed(LO_LIM)) begin
               s_stat = ST_OVERFLOW;
               s_res  = SIGNBIT;
            end else begin
               s_res = in_a << F;
            end
         end
         OP_TO_INT: s_res = W'($signed(in_a) >>> F);
         default: s_res = '0;
      endcase
      if (s_cmp) s_res = W'(1);
   end

   // ---------------- iteration pipeline ----------------
   logic           valid_ff [0:D];
   opcode_type     op_ff    [0:D];
   logic [W-1:0]   res_ff   [0:D];
   logic           cmp_ff   [0:D];
   status_type     stat_ff  [0:D];
   logic           neg_ff   [0:D];
   logic [W-1:0]   ma_ff    [0:D];
   logic [W-1:0]   mb_ff    [0:D];
   logic [2*W-1:0] acc_ff   [0:D];
   logic [W-1:0]   rem_ff   [0:D];
   logic [D-1:0]   quo_ff   [0:D];
   logic [D-1:0]   num_ff   [0:D];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
      end
      if (adv) begin
         op_ff[0]   <= in_op;
         res_ff[0]  <= s_res;
         cmp_ff[0]  <= s_cmp;
         stat_ff[0] <= s_stat;
         neg_ff[0]  <= na ^ nb;
         ma_ff[0]   <= ma;
         mb_ff[0]   <= mb;
         acc_ff[0]  <= '0;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         num_ff[0]  <= {ma, {F{1'b0}}};
      end
   end

   genvar k;
   generate
      for (k = 0; k < D; k++) begin : g_step
         logic [W:0]     rem_sh;
         logic           take;
         logic [W-1:0]   rem_in;
         logic [D-1:0]   quo_in;
         logic [2*W-1:0] acc_in;

         // one restoring divide step per stage
         assign rem_sh = {rem_ff[k], num_ff[k][D-1]};
         assign take   = rem_sh >= {1'b0, mb_ff[k]};
         assign rem_in = take ? W'(rem_sh - {1'b0, mb_ff[k]}) : W'(rem_sh);
         assign quo_in = {quo_ff[k][D-2:0], take};

         // one partial product per stage for the first W stages
         if (k < W) begin : g_mul
            assign acc_in = acc_ff[k] +
               (mb_ff[k][k] ? ((2*W)'(ma_ff[k]) << k) : '0);
         end else begin : g_hold
            assign acc_in = acc_ff[k];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else if (adv) begin
               valid_ff[k+1] <= valid_ff[k];
            end
            if (adv) begin
               op_ff[k+1]   <= op_ff[k];
               res_ff[k+1]  <= res_ff[k];
               cmp_ff[k+1]  <= cmp_ff[k];
               stat_ff[k+1] <= stat_ff[k];
               neg_ff[k+1]  <= neg_ff[k];
               ma_ff[k+1]   <= ma_ff[k];
               mb_ff[k+1]   <= mb_ff[k];
               acc_ff[k+1]  <= acc_in;
               rem_ff[k+1]  <= rem_in;
               quo_ff[k+1]  <= quo_in;
               num_ff[k+1]  <= num_ff[k] << 1;
            end
         end
      end
   endgenerate

   // ---------------- rounding stage ----------------
   logic [PW-1:0]   mul_rnd;
   logic [D:0]      div_rnd;
   logic [MAGW-1:0] mag_in;
   logic            use_mag_in;

   logic            r_valid_ff, r_cmp_ff, r_neg_ff, r_use_ff;
   logic [W-1:0]    r_res_ff;
   status_type      r_stat_ff;
   logic [MAGW-1:0] r_mag_ff;

   assign mul_rnd = ({1'b0, acc_ff[D]} + ROUND_ADD) >> F;
   // round half up on the remainder: 2r >= divisor
   assign div_rnd = {1'b0, quo_ff[D]} +
      (D+1)'({rem_ff[D], 1'b0} >= {1'b0, mb_ff[D]});

   always_comb begin
      mag_in     = MAGW'(mul_rnd);
      use_mag_in = 1'b0;
      if (op_ff[D] == OP_MUL) begin
         use_mag_in = 1'b1;
      end else if (op_ff[D] == OP_DIV && stat_ff[D] != ST_DIV_ZERO) begin
         mag_in     = MAGW'(div_rnd);
         use_mag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= valid_ff[D];
      end
      if (adv) begin
         r_res_ff  <= res_ff[D];
         r_cmp_ff  <= cmp_ff[D];
         r_stat_ff <= stat_ff[D];
         r_neg_ff  <= neg_ff[D];
         r_use_ff  <= use_mag_in;
         r_mag_ff  <= mag_in;
      end
   end

   // ---------------- saturation and output stage ----------------
   logic            neg_eff;
   logic [MAGW-1:0] limit;
   logic [W-1:0]    val_in;
   status_type      stat_in;

   logic            out_valid_ff, out_cmp_ff;
   logic [W-1:0]    out_val_ff;
   status_type      out_stat_ff;

   assign neg_eff = r_neg_ff && (r_mag_ff != '0);
   assign limit   = neg_eff ? LIM_NEG : LIM_POS;

   always_comb begin
      val_in  = r_res_ff;
      stat_in = r_stat_ff;
      if (r_use_ff) begin
         if (r_mag_ff > limit) begin
            stat_in = ST_OVERFLOW;
            val_in  = neg_eff ? SIGNBIT : POSMAX;
         end else begin
            val_in = neg_eff ? W'(-r_mag_ff) : W'(r_mag_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= r_valid_ff;
      end
      if (adv) begin
         out_val_ff  <= val_in;
         out_cmp_ff  <= r_cmp_ff;
         out_stat_ff <= stat_in;
      end
   end

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA'({out_stat_ff, out_cmp_ff, out_val_ff});

endmodule
